### design/b64e_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, constants and the character mapping of the base64 encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

  localparam logic [7:0] PAD_CHAR = 8'h3D;
  localparam int         QDEPTH   = 2;
  localparam int         QPW      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int         QCW      = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic       pad;
    logic [5:0] sextet;
  } code_t;

  // cnt holds the number of characters less one
  typedef struct packed {
    code_t [3:0] code;
    logic  [1:0] cnt;
    logic        last;
  } job_t;

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

### design/b64e_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64e channel interfaces
// Byte input channel and character output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface b64e_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, data_byte, final_byte, input ready);
  modport sink   (input valid, data_byte, final_byte, output ready);
endinterface

interface b64e_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last_char;

  modport source (output valid, out_char, last_char, input ready);
  modport sink   (input valid, out_char, last_char, output ready);
endinterface
`default_nettype wire

### design/b64e_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64e_front
// Accepts bytes, tracks the group position and builds a character job.
// ----------------------------------------------------------------------------
module b64e_front
  import b64e_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  b64e_byte_if.sink   raw,
  input  wire logic   q_full,
  output logic        q_push,
  output job_t        q_job
);

  typedef enum logic [1:0] {POS0, POS1, POS2} pos_t;

  pos_t       pos;
  pos_t       pos_next;
  logic [7:0] prev;
  logic [7:0] b;
  logic       fin;

  assign raw.ready = !q_full;
  assign q_push    = raw.valid && !q_full;
  assign b         = raw.data_byte;
  assign fin       = raw.final_byte;

  always_comb begin
    q_job      = '0;
    q_job.last = fin;
    pos_next   = POS0;
    case (pos)
      POS1: begin
        q_job.code[0].sextet = {prev[1:0], b[7:4]};
        if (fin) begin
          q_job.code[1].sextet = {b[3:0], 2'b00};
          q_job.code[2].pad    = 1'b1;
          q_job.cnt            = 2'd2;
        end else begin
          pos_next = POS2;
        end
      end
      POS2: begin
        q_job.code[0].sextet = {prev[3:0], b[7:6]};
        q_job.code[1].sextet = b[5:0];
        q_job.cnt            = 2'd1;
      end
      default: begin
        q_job.code[0].sextet = b[7:2];
        if (fin) begin
          q_job.code[1].sextet = {b[1:0], 4'b0000};
          q_job.code[2].pad    = 1'b1;
          q_job.code[3].pad    = 1'b1;
          q_job.cnt            = 2'd3;
        end else begin
          pos_next = POS1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= POS0;
    end else if (q_push) begin
      pos  <= pos_next;
      prev <= b;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (q_push && fin) |=> pos == POS0)
    else $error("group position not cleared after final byte");

  assert property (@(posedge clk) disable iff (rst)
    (q_push && pos == POS2) |-> q_job.cnt == 2'd1)
    else $error("group completion must yield two characters");

endmodule
`default_nettype wire

### design/b64e_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64e_queue
// Short job queue between the front and back parts.
// ----------------------------------------------------------------------------
module b64e_queue
  import b64e_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  output logic      full,
  input  wire logic pop,
  output logic      empty,
  output job_t      head
);

  job_t           store [QDEPTH];
  logic [QPW-1:0] wp;
  logic [QPW-1:0] rp;
  logic [QCW-1:0] cnt;

  assign full  = cnt == QCW'(QDEPTH);
  assign empty = cnt == '0;
  assign head  = store[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        store[wp] <= push_job;
        wp        <= (wp == QPW'(QDEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (pop) begin
        rp <= (rp == QPW'(QDEPTH - 1)) ? '0 : rp + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue overflow");

  assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue underflow");

endmodule
`default_nettype wire

### design/b64e_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64e_back
// Walks the head job one char per cycle unless stalled, into the output reg.
// ----------------------------------------------------------------------------
module b64e_back
  import b64e_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   q_empty,
  input  wire job_t   q_head,
  output logic        q_pop,
  b64e_char_if.source chars
);

  logic [1:0] idx;
  logic       ovalid;
  logic [7:0] ochar;
  logic       olast;
  logic       load;
  logic       at_end;
  code_t      sel;

  assign load   = !q_empty && (!ovalid || chars.ready);
  assign at_end = idx == q_head.cnt;
  assign q_pop  = load && at_end;
  assign sel    = q_head.code[idx];

  assign chars.valid     = ovalid;
  assign chars.out_char  = ochar;
  assign chars.last_char = olast;

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
      idx    <= '0;
    end else if (load) begin
      ovalid <= 1'b1;
      ochar  <= sel.pad ? PAD_CHAR : b64_char(sel.sextet);
      olast  <= q_head.last && at_end;
      idx    <= at_end ? 2'd0 : idx + 2'd1;
    end else if (chars.ready) begin
      ovalid <= 1'b0;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    !q_empty |-> idx <= q_head.cnt)
    else $error("character index past end of job");

  assert property (@(posedge clk) disable iff (rst)
    q_pop |=> idx == 2'd0)
    else $error("character index not rewound after job");

endmodule
`default_nettype wire

### design/base64_stream_encoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Streaming base64 encoder, standard alphabet with '=' padding.
// ----------------------------------------------------------------------------
//  channel  dir  payload                     note
//  raw      in   data_byte[7:0], final_byte  one message byte per transfer
//  encoded  out  out_char[7:0], last_char    one character per transfer
//
//  A byte is taken in the cycle it is offered while the job queue has room.
//  The character stage emits one character per cycle while encoded is ready;
//  a byte yields 1 to 4 characters; a long message settles near 4/3 per byte.
//  A byte's first character passes the job queue, then the output register.
//  Synchronous reset empties the queue and returns to group start.
//  A stall on encoded fills the two-entry job queue, then holds raw off.
// ----------------------------------------------------------------------------
module base64_stream_encoder
  import b64e_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  b64e_byte_if.sink   raw,
  b64e_char_if.source encoded
);

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  job_t q_job;
  job_t q_head;

  b64e_front u_front (
    .clk    (clk),
    .rst    (rst),
    .raw    (raw),
    .q_full (q_full),
    .q_push (q_push),
    .q_job  (q_job)
  );

  b64e_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (q_job),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  b64e_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .chars   (encoded)
  );

endmodule
`default_nettype wire

### test/base64_stream_encoder_tb.sv
// ----------------------------------------------------------------------------
// base64_stream_encoder_tb
// Drives messages into the encoder with random gaps on both channels. An
// internal encoder predicts every character and the last-character flag.
// Each character transfer is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module base64_stream_encoder_tb;
  import b64e_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_BYTES = 370;
  localparam string ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef enum logic [1:0] {GRP_EMPTY, GRP_ONE, GRP_TWO} grp_pos_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } enc_char_t;

  logic clk;
  logic rst;
  logic calm;
  int   mismatches = 0;
  int   cycles = 0;
  int   bytes_sent;

  logic [15:0] held_bits;
  grp_pos_t    held_pos;
  enc_char_t   expected_chars[$];

  b64e_byte_if raw ();
  b64e_char_if encoded ();

  base64_stream_encoder uut (
    .clk     (clk),
    .rst     (rst),
    .raw     (raw.sink),
    .encoded (encoded.source)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("base64_stream_encoder_tb failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    encoded.ready <= calm || ($urandom_range(99) >= 6);
  end

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    return ALPHABET[v];
  endfunction

  task automatic expect_char(input logic [7:0] ch, input logic last);
    enc_char_t e;
    e.ch   = ch;
    e.last = last;
    expected_chars.push_back(e);
  endtask

  // running encoder state, updated once per accepted byte
  task automatic predict_chars(input logic [7:0] b, input logic fin);
    logic [7:0] prev;
    prev = held_bits[7:0];
    case (held_pos)
      GRP_ONE: begin
        expect_char(sextet_char({prev[1:0], b[7:4]}), 1'b0);
        if (fin) begin
          expect_char(sextet_char({b[3:0], 2'b00}), 1'b0);
          expect_char(PAD_CHAR, 1'b1);
          held_bits = '0;
          held_pos  = GRP_EMPTY;
        end else begin
          held_bits = {prev, b};
          held_pos  = GRP_TWO;
        end
      end
      GRP_TWO: begin
        expect_char(sextet_char({prev[3:0], b[7:6]}), 1'b0);
        expect_char(sextet_char(b[5:0]), fin);
        held_bits = '0;
        held_pos  = GRP_EMPTY;
      end
      default: begin
        expect_char(sextet_char(b[7:2]), 1'b0);
        if (fin) begin
          expect_char(sextet_char({b[1:0], 4'b0000}), 1'b0);
          expect_char(PAD_CHAR, 1'b0);
          expect_char(PAD_CHAR, 1'b1);
          held_bits = '0;
          held_pos  = GRP_EMPTY;
        end else begin
          held_bits = {8'h00, b};
          held_pos  = GRP_ONE;
        end
      end
    endcase
  endtask

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0d: %s", cycles, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin : check_encoded_chars
    enc_char_t e;
    if (!rst && encoded.valid && encoded.ready) begin
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected char %02h last %0b",
                                  encoded.out_char, encoded.last_char));
      end else begin
        e = expected_chars.pop_front();
        if (encoded.out_char !== e.ch)
          report_mismatch($sformatf("out_char %02h, expected %02h",
                                    encoded.out_char, e.ch));
        if (encoded.last_char !== e.last)
          report_mismatch($sformatf("last_char %0b, expected %0b on %02h",
                                    encoded.last_char, e.last, e.ch));
      end
    end
  end

  // called and returns at a falling edge; valid is left high for the next byte
  task automatic send_byte(input logic [7:0] b, input logic fin);
    if (!calm) begin
      while ($urandom_range(99) < 6) begin
        raw.valid <= 1'b0;
        @(negedge clk);
      end
    end
    raw.valid      <= 1'b1;
    raw.data_byte  <= b;
    raw.final_byte <= fin;
    do @(posedge clk); while (!raw.ready);
    predict_chars(b, fin);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_message(input logic [7:0] msg[$]);
    foreach (msg[i]) send_byte(msg[i], i == msg.size() - 1);
  endtask

  task automatic test_single_byte_messages();
    send_message({8'h00});
    send_message({8'hFF});
    send_message({8'hFC});
    send_message({8'hF8});
  endtask

  task automatic test_two_byte_messages();
    send_message({8'h00, 8'h00});
    send_message({8'hFF, 8'hFF});
    send_message({8'h03, 8'hF0});
  endtask

  task automatic test_full_groups();
    send_message({8'h00, 8'h00, 8'h00});
    send_message({8'hFF, 8'hFF, 8'hFF});
    send_message({8'hFB, 8'hEF, 8'hBE});
    send_message({8'h12, 8'h34, 8'h56, 8'h78});
  endtask

  // back to back on both channels
  task automatic test_long_message_no_gaps();
    calm = 1'b1;
    for (int i = 0; i < 60; i++) send_byte(8'($urandom_range(255)), i == 59);
    calm = 1'b0;
  endtask

  task automatic test_random_messages();
    int len;
    while (bytes_sent < RANDOM_BYTES + 83) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      for (int i = 0; i < len; i++) send_byte(8'($urandom_range(255)), i == len - 1);
    end
  endtask

  initial begin
    rst            = 1'b1;
    calm           = 1'b0;
    bytes_sent     = 0;
    held_bits      = '0;
    held_pos       = GRP_EMPTY;
    raw.valid      = 1'b0;
    raw.data_byte  = 8'h00;
    raw.final_byte = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_single_byte_messages();
    test_two_byte_messages();
    test_full_groups();
    test_long_message_no_gaps();
    test_random_messages();

    raw.valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && expected_chars.size() == 0) begin
      $display("base64_stream_encoder_tb passed");
    end else begin
      $display("base64_stream_encoder_tb failed");
    end
    $finish;
  end

endmodule
